@@ src/ikst_pkg.sv @@
// Package for the integer key set table: table size, derived widths,
// operation and status codes. No dependencies.
package ikst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ADDR_W   = IDX_W + 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int ENTRY_W  = 7;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_FULL = 1'b1;

endpackage

@@ src/integer_key_set_table_top.sv @@
// Integer key set table: bounded set of distinct 32-bit keys, scanned by
// one shared comparator. Depends on ikst_pkg.
//
// Usage: raise start with an operation (add, remove, query) and a key while
// busy is low; the transaction is taken on that clock edge and busy rises.
// The table is then scanned one slot per cycle through a single key
// comparator fed by the key memory's registered read port, which finds both
// the slot holding the key and the lowest free slot. In the cycle after the
// last compare the table is updated, and on the next cycle the result
// (was_present, status, entry_count) shows for exactly one cycle under
// o_result_valid; the receiver cannot stall it, so capture it then. busy is
// already low in the strobe cycle, so a new transaction may be started
// there; until then busy holds off new transactions while every slot is
// scanned and the table is updated.
// Adding a new key to a full table is rejected with status 1. After reset
// all slots are empty at once: no clearing pass is needed.
module integer_key_set_table_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ikst_pkg::OP_W-1:0]   i_operation,
    input  logic signed [ikst_pkg::KEY_W-1:0] i_key,
    output logic                        o_result_valid,
    output logic                        o_was_present,
    output logic                        o_status,
    output logic [ikst_pkg::ENTRY_W-1:0] o_entry_count
);

    // One-hot sequencer: idle, scan the table, apply the update.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Captured transaction
    logic [ikst_pkg::OP_W-1:0]  r_op;
    logic [ikst_pkg::KEY_W-1:0] r_key;

    // Read issue counter: counts to CAPACITY, so one bit wider than the index
    logic [ikst_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic                        issue;

    // Key memory, valid bits and entry count
    logic [ikst_pkg::KEY_W-1:0]  r_key_mem [ikst_pkg::CAPACITY];
    logic [ikst_pkg::CAPACITY-1:0] r_slot_valid, n_slot_valid;
    logic [ikst_pkg::CNT_W-1:0]  r_count, n_count;

    // Compare stage: registered read data and its slot index
    logic [ikst_pkg::KEY_W-1:0]  r_rd_data;
    logic [ikst_pkg::IDX_W-1:0]  r_rd_idx;
    logic                        r_rd_vld;
    logic                        r_rd_last;

    // Scan results
    logic                        r_hit_found, n_hit_found;
    logic [ikst_pkg::IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic                        r_free_found, n_free_found;
    logic [ikst_pkg::IDX_W-1:0]  r_free_idx, n_free_idx;

    // Update and result
    logic                        mem_we;
    logic                        cur_valid;
    logic                        cur_match;
    logic                        accept;
    logic                        n_result_valid;
    logic                        n_status;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign issue  = (r_state == ST_SCAN) &&
                    (r_addr < ikst_pkg::ADDR_W'(ikst_pkg::CAPACITY));

    // Shared comparator on the slot coming out of the memory
    assign cur_valid = r_slot_valid[r_rd_idx];
    assign cur_match = r_rd_vld && cur_valid && (r_rd_data == r_key);

    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_hit_found    = r_hit_found;
        n_hit_idx      = r_hit_idx;
        n_free_found   = r_free_found;
        n_free_idx     = r_free_idx;
        n_slot_valid   = r_slot_valid;
        n_count        = r_count;
        n_result_valid = 1'b0;
        n_status       = ikst_pkg::STAT_DONE;
        mem_we         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state      = ST_SCAN;
                    n_addr       = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_addr = r_addr + ikst_pkg::ADDR_W'(1);
                end
                // keep the first hit and the lowest free slot
                if (cur_match && !r_hit_found) begin
                    n_hit_found = 1'b1;
                    n_hit_idx   = r_rd_idx;
                end
                if (r_rd_vld && !cur_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_rd_idx;
                end
                if (r_rd_vld && r_rd_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state        = ST_IDLE;
                n_result_valid = 1'b1;
                case (r_op)
                    ikst_pkg::OP_ADD: begin
                        if (!r_hit_found) begin
                            if (r_free_found) begin
                                mem_we                   = 1'b1;
                                n_slot_valid[r_free_idx] = 1'b1;
                                n_count = r_count + ikst_pkg::CNT_W'(1);
                            end else begin
                                n_status = ikst_pkg::STAT_FULL;
                            end
                        end
                    end
                    ikst_pkg::OP_REMOVE: begin
                        if (r_hit_found) begin
                            n_slot_valid[r_hit_idx] = 1'b0;
                            n_count = r_count - ikst_pkg::CNT_W'(1);
                        end
                    end
                    default: begin
                        // query and the unused code change nothing
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_addr         <= '0;
            r_rd_vld       <= 1'b0;
            r_hit_found    <= 1'b0;
            r_free_found   <= 1'b0;
            r_slot_valid   <= '0;
            r_count        <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_addr         <= n_addr;
            r_rd_vld       <= issue;
            r_hit_found    <= n_hit_found;
            r_free_found   <= n_free_found;
            r_slot_valid   <= n_slot_valid;
            r_count        <= n_count;
            o_result_valid <= n_result_valid;
        end
    end

    // Payload: captured transaction, scan indexes, result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_key <= i_key;
        end
        r_rd_idx   <= r_addr[ikst_pkg::IDX_W-1:0];
        r_rd_last  <= (r_addr == ikst_pkg::ADDR_W'(ikst_pkg::CAPACITY - 1));
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        if (n_result_valid) begin
            o_was_present <= r_hit_found;
            o_status      <= n_status;
            o_entry_count <= ikst_pkg::ENTRY_W'(n_count);
        end
    end

    // Key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_mem[r_free_idx] <= r_key;
        end
        if (issue) begin
            r_rd_data <= r_key_mem[r_addr[ikst_pkg::IDX_W-1:0]];
        end
    end

endmodule

@@ src/ikst_checker.sv @@
// Port-level checker for the integer key set table, bound to the top level.
// Depends on ikst_pkg and integer_key_set_table_top.
module ikst_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_result_valid,
    input logic                         o_was_present,
    input logic                         o_status,
    input logic [ikst_pkg::ENTRY_W-1:0] o_entry_count
);

    // An accepted transaction makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after accept");

    // A result follows a busy period.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a transaction in flight");

    // Result strobe lasts one cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held");

    // A rejected add never reports the key as present.
    a_full_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status) |-> !o_was_present)
        else $error("full status with key present");

    // Count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_entry_count <= ikst_pkg::ENTRY_W'(ikst_pkg::CAPACITY)))
        else $error("entry count above capacity");

endmodule

bind integer_key_set_table_top ikst_checker u_ikst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_was_present  (o_was_present),
    .o_status       (o_status),
    .o_entry_count  (o_entry_count)
);
